/* rtl/encoder_speed_estimator_assert.svh */
// assertion macros for the encoder speed estimator
// used by the top level only, no other dependencies
`ifndef ENCODER_SPEED_ESTIMATOR_ASSERT_SVH
`define ENCODER_SPEED_ESTIMATOR_ASSERT_SVH

`ifndef SYNTH
`define ESE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ESE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ESE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ESE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/esest_pkg.sv */
// shared types, register codes and microcode table of the encoder speed estimator
// no dependencies
`timescale 1ns / 1ps

package esest_pkg;

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LINES    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXTICKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 3'd5;

   localparam logic [15:0] RST_LINES    = 16'd512;
   localparam logic [7:0]  RST_PERIOD   = 8'd5;
   localparam logic        RST_INVERT   = 1'b0;
   localparam logic [14:0] RST_DEADZONE = 15'd0;
   localparam logic [14:0] RST_MAXTICKS = 15'd32767;
   localparam logic [15:0] RST_RADIUS   = 16'd0;

   // datapath widths and constants
   localparam int DELTA_W = 16;
   localparam int TICK_W  = 15;
   localparam int PROD_W  = 31;
   localparam int DIV_W   = 24;
   localparam int RPM_W   = 40;
   localparam int SPEED_W = 48;
   localparam int QX_W    = 48;
   localparam int PP_W    = 56;

   localparam logic [15:0]     RPM_SCALE   = 16'd60000;
   localparam logic [12:0]     TWO_PI_Q16  = 13'd6862;
   localparam logic [QX_W-1:0] RPM_POS_LIM = 48'h00_7F_FFFF_FFFF;
   localparam logic [QX_W-1:0] RPM_NEG_LIM = 48'h00_80_0000_0000;
   localparam logic [RPM_W-1:0] RPM_MAX    = 40'h7F_FFFF_FFFF;
   localparam logic [RPM_W-1:0] RPM_MIN    = 40'h80_0000_0000;

   // microcode
   localparam int STEP_W = 4;
   localparam int OP_W   = 4;
   localparam int COND_W = 3;

   localparam logic [OP_W-1:0] OP_IDLE  = 4'd0;
   localparam logic [OP_W-1:0] OP_DIFF  = 4'd1;
   localparam logic [OP_W-1:0] OP_INV   = 4'd2;
   localparam logic [OP_W-1:0] OP_LIMIT = 4'd3;
   localparam logic [OP_W-1:0] OP_PREP  = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
   localparam logic [OP_W-1:0] OP_SAT   = 4'd6;
   localparam logic [OP_W-1:0] OP_FILT  = 4'd7;
   localparam logic [OP_W-1:0] OP_ABS   = 4'd8;
   localparam logic [OP_W-1:0] OP_MULA  = 4'd9;
   localparam logic [OP_W-1:0] OP_MULB  = 4'd10;
   localparam logic [OP_W-1:0] OP_MULC  = 4'd11;
   localparam logic [OP_W-1:0] OP_MULD  = 4'd12;
   localparam logic [OP_W-1:0] OP_SIGN  = 4'd13;
   localparam logic [OP_W-1:0] OP_WRITE = 4'd14;
   localparam logic [OP_W-1:0] OP_NOP   = 4'd15;

   localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
   localparam logic [COND_W-1:0] C_NO_REQ     = 3'd2;
   localparam logic [COND_W-1:0] C_NOT_PRIMED = 3'd3;
   localparam logic [COND_W-1:0] C_NO_UPD     = 3'd4;
   localparam logic [COND_W-1:0] C_CNT_NZ     = 3'd5;
   localparam logic [COND_W-1:0] C_OUT_BUSY   = 3'd6;

   localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] S_DIFF  = 4'd1;
   localparam logic [STEP_W-1:0] S_INV   = 4'd2;
   localparam logic [STEP_W-1:0] S_LIMIT = 4'd3;
   localparam logic [STEP_W-1:0] S_PREP  = 4'd4;
   localparam logic [STEP_W-1:0] S_DIV   = 4'd5;
   localparam logic [STEP_W-1:0] S_SAT   = 4'd6;
   localparam logic [STEP_W-1:0] S_FILT  = 4'd7;
   localparam logic [STEP_W-1:0] S_ABS   = 4'd8;
   localparam logic [STEP_W-1:0] S_MULA  = 4'd9;
   localparam logic [STEP_W-1:0] S_MULB  = 4'd10;
   localparam logic [STEP_W-1:0] S_MULC  = 4'd11;
   localparam logic [STEP_W-1:0] S_MULD  = 4'd12;
   localparam logic [STEP_W-1:0] S_SIGN  = 4'd13;
   localparam logic [STEP_W-1:0] S_WRITE = 4'd14;
   localparam logic [STEP_W-1:0] S_RET   = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } esest_uword_type;

   typedef struct packed {
      logic no_req;
      logic not_primed;
      logic no_upd;
      logic cnt_nz;
      logic out_busy;
   } esest_stat_type;

   function automatic esest_uword_type esest_ucode(input logic [STEP_W-1:0] addr);
      esest_uword_type uw;
      unique case (addr)
         S_IDLE:  uw = '{OP_IDLE,  C_NO_REQ,     S_IDLE};
         S_DIFF:  uw = '{OP_DIFF,  C_NOT_PRIMED, S_ABS};
         S_INV:   uw = '{OP_INV,   C_NEVER,      S_IDLE};
         S_LIMIT: uw = '{OP_LIMIT, C_NO_UPD,     S_ABS};
         S_PREP:  uw = '{OP_PREP,  C_NEVER,      S_IDLE};
         S_DIV:   uw = '{OP_DIV,   C_CNT_NZ,     S_DIV};
         S_SAT:   uw = '{OP_SAT,   C_NEVER,      S_IDLE};
         S_FILT:  uw = '{OP_FILT,  C_NEVER,      S_IDLE};
         S_ABS:   uw = '{OP_ABS,   C_NEVER,      S_IDLE};
         S_MULA:  uw = '{OP_MULA,  C_NEVER,      S_IDLE};
         S_MULB:  uw = '{OP_MULB,  C_NEVER,      S_IDLE};
         S_MULC:  uw = '{OP_MULC,  C_NEVER,      S_IDLE};
         S_MULD:  uw = '{OP_MULD,  C_NEVER,      S_IDLE};
         S_SIGN:  uw = '{OP_SIGN,  C_NEVER,      S_IDLE};
         S_WRITE: uw = '{OP_WRITE, C_OUT_BUSY,   S_WRITE};
         default: uw = '{OP_NOP,   C_ALWAYS,     S_IDLE};
      endcase
      return uw;
   endfunction

endpackage

/* rtl/esest_seq.sv */
// microcode sequencer: step counter, control table lookup and conditional jumps
// depends on esest_pkg
`timescale 1ns / 1ps

module esest_seq
   import esest_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  esest_stat_type      stat,
   output logic [OP_W-1:0]     op
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   esest_uword_type   uw;
   logic              take;

   assign uw = esest_ucode(step_ff);
   assign op = uw.op;

   always_comb begin
      unique case (uw.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NO_REQ:     take = stat.no_req;
         C_NOT_PRIMED: take = stat.not_primed;
         C_NO_UPD:     take = stat.no_upd;
         C_CNT_NZ:     take = stat.cnt_nz;
         C_OUT_BUSY:   take = stat.out_busy;
         default:      take = 1'b0;
      endcase
      step_in = take ? uw.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* rtl/encoder_speed_estimator.sv */
// encoder speed estimator: top level with register file, datapath and result register
// depends on esest_pkg, esest_seq and encoder_speed_estimator_assert.svh
// one item in flight at a time; from accept to rsp_valid: difference, invert, limit, divide
// prep, restoring divide, saturate, filter, abs, multiply, sign, write (waits on rsp_stall);
// the first item after reset and items with zero line count or period skip to abs
// reset: synchronous; configuration registers take their reset values, rpm state and baseline clear
`timescale 1ns / 1ps

`include "encoder_speed_estimator_assert.svh"

module encoder_speed_estimator
   import esest_pkg::*;
#(
   parameter int COUNT_WIDTH   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_raw_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DELTA_W-1:0]  rsp_tick_delta,
   output logic signed [RPM_W-1:0]    rsp_rpm_instant,
   output logic signed [RPM_W-1:0]    rsp_rpm_filtered,
   output logic signed [SPEED_W-1:0]  rsp_speed_cm_s,
   output logic                       rsp_rpm_updated,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int CW    = COUNT_WIDTH;
   localparam int EW    = (COUNT_WIDTH + 2 > 17) ? COUNT_WIDTH + 2 : 17;
   localparam int NUM_W = PROD_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   // configuration
   logic [15:0]       lines_ff,  lines_in;
   logic [7:0]        period_ff, period_in;
   logic              invert_ff, invert_in;
   logic [TICK_W-1:0] dead_ff,   dead_in;
   logic [TICK_W-1:0] max_ff,    max_in;
   logic [15:0]       radius_ff, radius_in;

   // control state
   logic              primed_ff, primed_in;
   logic              upd_ff,    upd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     last_ff,   last_in;
   logic signed [RPM_W-1:0] inst_ff, inst_in;
   logic signed [RPM_W-1:0] filt_ff, filt_in;

   // working registers
   logic [CW-1:0]            raw_ff,   raw_in;
   logic signed [EW-1:0]     diff_ff,  diff_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [TICK_W-1:0]        mag_ff,   mag_in;
   logic                     neg_ff,   neg_in;
   logic [NUM_W-1:0]         num_ff,   num_in;
   logic [DIV_W-1:0]         div_ff,   div_in;
   logic [DIV_W-1:0]         rem_ff,   rem_in;
   logic [CNT_W-1:0]         cnt_ff,   cnt_in;
   logic [RPM_W-1:0]         smag_ff,  smag_in;
   logic                     sneg_ff,  sneg_in;
   logic [PP_W-1:0]          prod_ff,  prod_in;
   logic [SPEED_W-1:0]       acc_ff,   acc_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;

   // result register
   logic signed [DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;
   logic signed [RPM_W-1:0]   rsp_inst_ff,  rsp_inst_in;
   logic signed [RPM_W-1:0]   rsp_filt_ff,  rsp_filt_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                      rsp_upd_ff,   rsp_upd_in;

   logic [OP_W-1:0] op;
   esest_stat_type  stat;
   logic            out_busy;

   // combinational helpers
   logic [CW-1:0]         d_raw;
   logic signed [EW-1:0]  dz_s, mx_s, neg_diff;
   logic                  in_dz, over, under;
   logic [PROD_W-1:0]     scaled;
   logic [DIV_W:0]        trial;
   logic                  qbit;
   logic [QX_W-1:0]       qx;
   logic [RPM_W-1:0]      q40;
   logic signed [RPM_W:0] fsum;
   logic [39:0]           pp_lo;
   logic [31:0]           pp_hi;
   logic [44:0]           hi_prod;
   logic [36:0]           lo_prod;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (op != OP_IDLE);
   assign csr_ready = 1'b1;

   assign stat.no_req     = !req_valid;
   assign stat.not_primed = !primed_ff;
   assign stat.no_upd     = !upd_ff;
   assign stat.cnt_nz     = (cnt_ff != '0);
   assign stat.out_busy   = out_busy;

   esest_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .op    (op)
   );

   assign d_raw    = raw_ff - last_ff;
   assign dz_s     = $signed(EW'(dead_ff));
   assign mx_s     = $signed(EW'(max_ff));
   assign neg_diff = -diff_ff;
   assign in_dz    = (diff_ff > -dz_s) && (diff_ff < dz_s);
   assign over     = (diff_ff > mx_s);
   assign under    = (diff_ff < -mx_s);
   assign scaled   = PROD_W'(mag_ff) * PROD_W'(RPM_SCALE);
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign qbit     = (trial >= {1'b0, div_ff});
   assign qx       = QX_W'(num_ff);
   assign q40      = RPM_W'(num_ff);
   assign fsum     = {inst_ff[RPM_W-1], inst_ff} + {filt_ff[RPM_W-1], filt_ff};
   assign pp_lo    = smag_ff[23:0] * radius_ff;
   assign pp_hi    = smag_ff[39:24] * radius_ff;
   assign hi_prod  = prod_ff[55:24] * TWO_PI_Q16;
   assign lo_prod  = prod_ff[23:0] * TWO_PI_Q16;

   always_comb begin
      lines_in     = lines_ff;
      period_in    = period_ff;
      invert_in    = invert_ff;
      dead_in      = dead_ff;
      max_in       = max_ff;
      radius_in    = radius_ff;
      primed_in    = primed_ff;
      upd_in       = upd_ff;
      last_in      = last_ff;
      inst_in      = inst_ff;
      filt_in      = filt_ff;
      raw_in       = raw_ff;
      diff_in      = diff_ff;
      delta_in     = delta_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      smag_in      = smag_ff;
      sneg_in      = sneg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      speed_in     = speed_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LINES:    lines_in  = csr_data;
            CSR_PERIOD:   period_in = csr_data[7:0];
            CSR_INVERT:   invert_in = csr_data[0];
            CSR_DEADZONE: dead_in   = csr_data[TICK_W-1:0];
            CSR_MAXTICKS: max_in    = csr_data[TICK_W-1:0];
            CSR_RADIUS:   radius_in = csr_data;
            default: ;
         endcase
      end

      unique case (op)
         OP_IDLE: begin
            if (req_valid) begin
               raw_in = CW'(req_raw_count);
            end
         end
         OP_DIFF: begin
            diff_in   = EW'($signed(d_raw));
            last_in   = raw_ff;
            primed_in = 1'b1;
            upd_in    = primed_ff && (lines_ff != '0) && (period_ff != '0);
            delta_in  = '0;
            neg_in    = 1'b0;
         end
         OP_INV: begin
            if (invert_ff) begin
               diff_in = neg_diff;
            end
         end
         OP_LIMIT: begin
            neg_in = !in_dz && diff_ff[EW-1];
            if (in_dz) begin
               delta_in = '0;
               mag_in   = '0;
            end else if (over) begin
               delta_in = DELTA_W'(mx_s);
               mag_in   = max_ff;
            end else if (under) begin
               delta_in = DELTA_W'(-mx_s);
               mag_in   = max_ff;
            end else begin
               delta_in = DELTA_W'(diff_ff);
               mag_in   = diff_ff[EW-1] ? TICK_W'(neg_diff) : TICK_W'(diff_ff);
            end
         end
         OP_PREP: begin
            num_in = NUM_W'(scaled) << FRACTION_BITS;
            div_in = DIV_W'(lines_ff) * DIV_W'(period_ff);
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
         end
         OP_DIV: begin
            rem_in = qbit ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
            num_in = {num_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_SAT: begin
            if (neg_ff) begin
               inst_in = (qx > RPM_NEG_LIM) ? $signed(RPM_MIN) : -$signed(q40);
            end else begin
               inst_in = (qx > RPM_POS_LIM) ? $signed(RPM_MAX) : $signed(q40);
            end
         end
         OP_FILT: begin
            filt_in = fsum[RPM_W:1];
         end
         OP_ABS: begin
            sneg_in = filt_ff[RPM_W-1];
            smag_in = filt_ff[RPM_W-1] ? RPM_W'(-filt_ff) : RPM_W'(filt_ff);
         end
         OP_MULA: begin
            prod_in = PP_W'(pp_lo);
         end
         OP_MULB: begin
            prod_in = prod_ff + {pp_hi, 24'b0};
         end
         OP_MULC: begin
            acc_in = SPEED_W'(hi_prod);
         end
         OP_MULD: begin
            acc_in = acc_ff + SPEED_W'(lo_prod[36:24]);
         end
         OP_SIGN: begin
            speed_in = sneg_ff ? -$signed(acc_ff) : $signed(acc_ff);
         end
         OP_WRITE: begin
            if (!out_busy) begin
               rsp_delta_in = delta_ff;
               rsp_inst_in  = inst_ff;
               rsp_filt_in  = filt_ff;
               rsp_speed_in = speed_ff;
               rsp_upd_in   = upd_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff     <= RST_LINES;
         period_ff    <= RST_PERIOD;
         invert_ff    <= RST_INVERT;
         dead_ff      <= RST_DEADZONE;
         max_ff       <= RST_MAXTICKS;
         radius_ff    <= RST_RADIUS;
         primed_ff    <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         inst_ff      <= '0;
         filt_ff      <= '0;
      end else begin
         lines_ff     <= lines_in;
         period_ff    <= period_in;
         invert_ff    <= invert_in;
         dead_ff      <= dead_in;
         max_ff       <= max_in;
         radius_ff    <= radius_in;
         primed_ff    <= primed_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         inst_ff      <= inst_in;
         filt_ff      <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      diff_ff      <= diff_in;
      delta_ff     <= delta_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      num_ff       <= num_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      smag_ff      <= smag_in;
      sneg_ff      <= sneg_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      speed_ff     <= speed_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_inst_ff  <= rsp_inst_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tick_delta   = rsp_delta_ff;
   assign rsp_rpm_instant  = rsp_inst_ff;
   assign rsp_rpm_filtered = rsp_filt_ff;
   assign rsp_speed_cm_s   = rsp_speed_ff;
   assign rsp_rpm_updated  = rsp_upd_ff;

   `ESE_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ESE_ASSERT_IMP(a_result_needs_prime, clock, reset, rsp_valid, primed_ff)
   `ESE_ASSERT_NXT(a_divide_ends, clock, reset, (op == OP_DIV) && (cnt_ff == '0), op == OP_SAT)

endmodule
